### rtl/mmpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmpf_pkg
// shared types and constants of the median-mean pixel filter
// ----------------------------------------------------------------------------
package mmpf_pkg;

   localparam int WIN_COLS   = 3;
   localparam int WIN_ROWS   = 3;
   localparam int WIN_SIZE   = WIN_COLS * WIN_ROWS;
   localparam int CENTER_IDX = WIN_SIZE / 2;
   localparam int PIX_W      = 8;
   localparam int SUM_W      = 12;
   localparam int CNT_W      = 4;
   localparam int STEP_W     = 3;
   localparam int DIVISOR    = 10;

   localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(WIN_SIZE - 1);
   localparam logic [CNT_W-1:0]  CNT_CENTER = CNT_W'(CENTER_IDX);
   localparam logic [CNT_W-1:0]  MED_RANK   = CNT_W'(CENTER_IDX + 1);
   localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(PIX_W - 1);
   localparam logic [SUM_W-1:0]  DIV_CMP    = SUM_W'(DIVISOR * (2 ** (PIX_W - 1)));

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MEDIAN,
      ST_SUM,
      ST_DIVIDE,
      ST_DONE
   } mmpf_state_type;

   typedef struct packed {
      logic load;
      logic first;
      logic center;
      logic med_step;
      logic div_load;
      logic div_step;
   } mmpf_ctrl_type;

endpackage
`default_nettype wire

### rtl/mmpf_chan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmpf_chan
// one color channel: window shift line, running sum without the center,
// bit-serial median msb first and bit-serial division by ten
// ----------------------------------------------------------------------------
module mmpf_chan import mmpf_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mmpf_ctrl_type       ctrl,
   input  wire logic [PIX_W-1:0]    pix,
   output logic      [PIX_W-1:0]    result
);

   logic [PIX_W-1:0]    win_ff [WIN_SIZE];
   logic [PIX_W-1:0]    win_in [WIN_SIZE];
   logic [WIN_SIZE-1:0] gt_ff, gt_in;
   logic [WIN_SIZE-1:0] lt_ff, lt_in;
   logic [WIN_SIZE-1:0] eff;
   logic [CNT_W-1:0]    ones;
   logic                med_bit;
   logic [PIX_W-1:0]    med_ff, med_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]    addend;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [PIX_W-1:0]    quo_ff, quo_in;

   // median bit: at least rank-many values show a one at this weight
   always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         eff[i] = gt_ff[i] | (~lt_ff[i] & win_ff[i][PIX_W-1]);
      end
      ones    = CNT_W'($countones(eff));
      med_bit = (ones >= MED_RANK);
   end

   always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         win_in[i] = win_ff[i];
      end
      gt_in  = gt_ff;
      lt_in  = lt_ff;
      med_in = med_ff;
      if (ctrl.load) begin
         for (int i = 0; i < WIN_SIZE - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[WIN_SIZE-1] = pix;
         gt_in = '0;
         lt_in = '0;
      end else if (ctrl.med_step) begin
         for (int i = 0; i < WIN_SIZE; i++) begin
            win_in[i] = {win_ff[i][PIX_W-2:0], 1'b0};
            if (!gt_ff[i] && !lt_ff[i]) begin
               if (win_ff[i][PIX_W-1] && !med_bit) begin
                  gt_in[i] = 1'b1;
               end
               if (!win_ff[i][PIX_W-1] && med_bit) begin
                  lt_in[i] = 1'b1;
               end
            end
         end
         med_in = {med_ff[PIX_W-2:0], med_bit};
      end
   end

   // center pixel is left out of the sum
   always_comb begin
      addend = ctrl.center ? '0 : SUM_W'(pix);
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = ctrl.first ? addend : acc_ff + addend;
      end
   end

   // restoring division, one quotient bit per beat msb first
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctrl.div_load) begin
         rem_in = acc_ff + SUM_W'({med_ff, 1'b0});
      end else if (ctrl.div_step) begin
         if (rem_ff >= DIV_CMP) begin
            rem_in = SUM_W'({rem_ff - DIV_CMP, 1'b0});
            quo_in = {quo_ff[PIX_W-2:0], 1'b1};
         end else begin
            rem_in = SUM_W'({rem_ff, 1'b0});
            quo_in = {quo_ff[PIX_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         win_ff[i] <= win_in[i];
      end
      med_ff <= med_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gt_ff <= '0;
         lt_ff <= '0;
      end else begin
         gt_ff <= gt_in;
         lt_ff <= lt_in;
      end
   end

   assign result = quo_ff;

endmodule
`default_nettype wire

### rtl/median_mean_pixel_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_mean_pixel_filter_unit
// 3x3 rgb window filter: mean of the window with the center replaced by the
// median at weight two, floor divided by ten
// ----------------------------------------------------------------------------
// Pixels of a window arrive in row order, one beat per cycle while req_tready
// is high, nine beats per window. After the ninth beat the input stalls for
// the bit-serial median search (one bit per cycle over the nine stored
// values), the forming of the numerator and the bit-serial division by ten,
// then for the move of the result into the output register once that
// register is free. The three color channels are worked on side by side. A
// held result blocks only the end of the next window's computation, not the
// loading of its pixels.
// ----------------------------------------------------------------------------
module median_mean_pixel_filter_unit import mmpf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red_in, green_in, blue_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata    // red_out, green_out, blue_out
);

   mmpf_state_type    st_ff, st_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_data_ff;
   logic              accept;
   logic              load_rsp;
   mmpf_ctrl_type     ctrl;
   logic [PIX_W-1:0]  red_q, green_q, blue_q;

   assign accept = req_tvalid & req_tready;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_LOAD: begin
            if (accept && cnt_ff == CNT_LAST) begin
               st_in = ST_MEDIAN;
            end
         end
         ST_MEDIAN: begin
            if (step_ff == STEP_LAST) begin
               st_in = ST_SUM;
            end
         end
         ST_SUM: begin
            st_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (step_ff == STEP_LAST) begin
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               st_in = ST_LOAD;
            end
         end
         default: begin
            st_in = ST_LOAD;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready    = 1'b0;
      load_rsp      = 1'b0;
      ctrl          = '0;
      case (st_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
         end
         ST_MEDIAN: begin
            ctrl.med_step = 1'b1;
         end
         ST_SUM: begin
            ctrl.div_load = 1'b1;
         end
         ST_DIVIDE: begin
            ctrl.div_step = 1'b1;
         end
         ST_DONE: begin
            load_rsp = ~rsp_valid_ff | rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      ctrl.load   = req_tvalid & req_tready;
      ctrl.first  = (cnt_ff == '0);
      ctrl.center = (cnt_ff == CNT_CENTER);
   end

   always_comb begin
      step_in = '0;
      if (st_ff == ST_MEDIAN || st_ff == ST_DIVIDE) begin
         step_in = step_ff + 1'b1;
      end
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = (cnt_ff == CNT_LAST) ? '0 : cnt_ff + 1'b1;
      end
      rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_LOAD;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {blue_q, green_q, red_q};
      end
   end

   mmpf_chan u_red (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .pix    (req_tdata[7:0]),
      .result (red_q)
   );

   mmpf_chan u_green (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .pix    (req_tdata[15:8]),
      .result (green_q)
   );

   mmpf_chan u_blue (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .pix    (req_tdata[23:16]),
      .result (blue_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/mmpf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmpf_checker
// port-level checks of the median-mean pixel filter, bound to the top level
// ----------------------------------------------------------------------------
module mmpf_checker import mmpf_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   logic [CNT_W-1:0] beat_ff, beat_in;
   logic             in_beat;

   assign in_beat = req_tvalid & req_tready;

   always_comb begin
      beat_in = beat_ff;
      if (in_beat) begin
         beat_in = (beat_ff == CNT_LAST) ? '0 : beat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // the last beat of a window stops the input for the computation
   a_window_stall: assert property (@(posedge clock) disable iff (reset)
      in_beat && beat_ff == CNT_LAST |=> !req_tready ##8 !req_tready)
      else $error("input taken during window computation");

   // a new result only appears just after the input was stalled, with no window partly loaded
   a_rsp_after_compute: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready) && beat_ff == '0)
      else $error("result outside window boundary");

   // a full window is on hand whenever a result starts
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      in_beat && beat_ff != CNT_LAST |=> !$rose(rsp_tvalid))
      else $error("result raised mid window");

endmodule

bind median_mean_pixel_filter_unit mmpf_checker u_checker (.*);
`default_nettype wire
